// File: sv/pidc_pkg.sv
package pidc_pkg;

    localparam int PosW   = 32;
    localparam int GainW  = 31;
    localparam int TickW  = 16;
    localparam int DriveW = 16;
    localparam int FracW  = 16;
    localparam int IdxW   = 3;
    localparam int MulAW  = PosW + 1;
    localparam int MulBW  = PosW;
    localparam int ProdW  = MulAW + MulBW;
    localparam int AccW   = ProdW - FracW;

    localparam logic [GainW-1:0] GAIN_P_RST       = 31'd3276800;
    localparam logic [GainW-1:0] GAIN_I_RST       = 31'd65536;
    localparam logic [GainW-1:0] GAIN_D_RST       = 31'd655;
    localparam logic [TickW-1:0] TICK_PERIOD_RST  = 16'd655;
    localparam logic [GainW-1:0] TICK_RATE_RST    = 31'd6553600;
    localparam logic [GainW-1:0] DRIVE_LIMIT_RST  = 31'd343146;
    localparam logic [GainW-1:0] WINDUP_LIMIT_RST = 31'd6863;

    typedef enum logic [IdxW-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_TICK_PERIOD,
        REG_TICK_RATE,
        REG_DRIVE_LIMIT,
        REG_WINDUP_LIMIT
    } reg_idx_t;

    typedef enum logic [2:0] {
        MSEL_INT,
        MSEL_DER,
        MSEL_P,
        MSEL_I,
        MSEL_D
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_INT,
        ST_UPD_INT,
        ST_UPD_DER,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        logic     upd_int;
        logic     upd_der;
        logic     acc_clr;
        logic     acc_add;
        logic     out_load;
    } dp_cmd_t;

endpackage

// File: sv/pid_position_controller.sv
// PID position controller for one joint, signed Q16.16.
// Input channel (in_valid/in_ready): one control tick per item with target_pos,
// measured_pos and restart. Output channel (out_valid/out_ready): one drive
// value per item, clamped to drive_limit and truncated toward zero.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 gain_p, 1 gain_i, 2 gain_d, 3 tick_period, 4 tick_rate, 5 drive_limit,
// 6 windup_limit); other indexes are ignored. Write only while idle.
// Sequence: the item is accepted in ST_IDLE, and drive is registered from ST_FINISH
// once the output register is free. Seven busy steps are set by the single 33x32
// multiplier, which runs five dependent products in turn (integrator step,
// derivative, then the three gain products into the accumulator), followed by an
// idle state in which the next item is accepted.
// Reset clears integrator and previous error, loads the default gains and
// limits, and leaves the block idle with no result pending.
// A stalled receiver holds drive in the output register; the next item can
// still be accepted and computed, and waits in its last step until the
// output register is taken.
module pid_position_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pidc_pkg::IdxW-1:0]           cfg_index,
    input  logic [pidc_pkg::GainW-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [pidc_pkg::PosW-1:0]    target_pos,
    input  logic signed [pidc_pkg::PosW-1:0]    measured_pos,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pidc_pkg::DriveW-1:0]  drive
);
    import pidc_pkg::*;

    dp_cmd_t cmd;

    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pidc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .target_pos   (target_pos),
        .measured_pos (measured_pos),
        .restart      (restart),
        .cmd          (cmd),
        .drive        (drive)
    );

endmodule

// File: sv/pidc_ctrl.sv
module pidc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output pidc_pkg::dp_cmd_t cmd
);
    import pidc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_MUL_INT;
            ST_MUL_INT: state_next = ST_UPD_INT;
            ST_UPD_INT: state_next = ST_UPD_DER;
            ST_UPD_DER: state_next = ST_MUL_I;
            ST_MUL_I:   state_next = ST_MUL_D;
            ST_MUL_D:   state_next = ST_ACC_D;
            ST_ACC_D:   state_next = ST_FINISH;
            ST_FINISH:  if (slot_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MSEL_INT;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL_INT: cmd.mul_sel = MSEL_INT;
            ST_UPD_INT:
            begin
                cmd.upd_int = 1'b1;
                cmd.mul_sel = MSEL_DER;
            end
            ST_UPD_DER:
            begin
                cmd.upd_der = 1'b1;
                cmd.mul_sel = MSEL_P;
                cmd.acc_clr = 1'b1;
            end
            ST_MUL_I:
            begin
                cmd.mul_sel = MSEL_I;
                cmd.acc_add = 1'b1;
            end
            ST_MUL_D:
            begin
                cmd.mul_sel = MSEL_D;
                cmd.acc_add = 1'b1;
            end
            ST_ACC_D:   cmd.acc_add = 1'b1;
            ST_FINISH:  cmd.out_load = slot_free;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/pidc_datapath.sv
module pidc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pidc_pkg::IdxW-1:0]           cfg_index,
    input  logic [pidc_pkg::GainW-1:0]          cfg_data,
    input  logic signed [pidc_pkg::PosW-1:0]    target_pos,
    input  logic signed [pidc_pkg::PosW-1:0]    measured_pos,
    input  logic                                restart,
    input  pidc_pkg::dp_cmd_t                   cmd,
    output logic signed [pidc_pkg::DriveW-1:0]  drive
);
    import pidc_pkg::*;

    logic [GainW-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [TickW-1:0] tick_period_reg;
    logic [GainW-1:0] tick_rate_reg, drive_limit_reg, windup_limit_reg;

    logic signed [PosW-1:0]   integ_reg, integ_next;
    logic signed [PosW-1:0]   last_err_reg, last_err_next;
    logic signed [PosW-1:0]   err_reg;
    logic signed [PosW-1:0]   deriv_reg, deriv_next;
    logic signed [ProdW-1:0]  prod_reg, prod_next;
    logic signed [AccW-1:0]   acc_reg, acc_next;
    logic signed [DriveW-1:0] drive_reg, drive_next;

    logic signed [PosW:0]     pos_diff;
    logic signed [PosW-1:0]   err_sat;
    logic signed [PosW:0]     err_delta;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [PosW-1:0]   int_step;
    logic signed [PosW:0]     int_sum;
    logic signed [PosW:0]     wl_pos;
    logic signed [PosW:0]     wl_neg;
    logic signed [AccW-1:0]   prod_q;
    logic signed [AccW-1:0]   dl_pos;
    logic signed [PosW-1:0]   sum_clamp;
    logic [PosW-1:0]          sum_mag;
    logic [DriveW-1:0]        drive_mag;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= GAIN_P_RST;
            gain_i_reg       <= GAIN_I_RST;
            gain_d_reg       <= GAIN_D_RST;
            tick_period_reg  <= TICK_PERIOD_RST;
            tick_rate_reg    <= TICK_RATE_RST;
            drive_limit_reg  <= DRIVE_LIMIT_RST;
            windup_limit_reg <= WINDUP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GAIN_P:       gain_p_reg       <= cfg_data;
                REG_GAIN_I:       gain_i_reg       <= cfg_data;
                REG_GAIN_D:       gain_d_reg       <= cfg_data;
                REG_TICK_PERIOD:  tick_period_reg  <= cfg_data[TickW-1:0];
                REG_TICK_RATE:    tick_rate_reg    <= cfg_data;
                REG_DRIVE_LIMIT:  drive_limit_reg  <= cfg_data;
                REG_WINDUP_LIMIT: windup_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // saturated position error
    always_comb
    begin
        pos_diff = {target_pos[PosW-1], target_pos} - {measured_pos[PosW-1], measured_pos};
        if (pos_diff[PosW] != pos_diff[PosW-1])
            err_sat = pos_diff[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
        else
            err_sat = pos_diff[PosW-1:0];
    end

    assign err_delta = {err_reg[PosW-1], err_reg} - {last_err_reg[PosW-1], last_err_reg};

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_INT:
            begin
                mul_a = {err_reg[PosW-1], err_reg};
                mul_b = {{(MulBW-TickW){1'b0}}, tick_period_reg};
            end
            MSEL_DER:
            begin
                mul_a = err_delta;
                mul_b = {1'b0, tick_rate_reg};
            end
            MSEL_P:
            begin
                mul_a = {err_reg[PosW-1], err_reg};
                mul_b = {1'b0, gain_p_reg};
            end
            MSEL_I:
            begin
                mul_a = {integ_reg[PosW-1], integ_reg};
                mul_b = {1'b0, gain_i_reg};
            end
            MSEL_D:
            begin
                mul_a = {deriv_reg[PosW-1], deriv_reg};
                mul_b = {1'b0, gain_d_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // floor of the registered product to Q33.16
    assign prod_q = prod_reg[ProdW-1:FracW];

    // integrator and error history
    always_comb
    begin
        int_step = prod_reg[FracW+PosW-1:FracW];
        int_sum  = {integ_reg[PosW-1], integ_reg} + {int_step[PosW-1], int_step};
        wl_pos   = {2'b00, windup_limit_reg};
        wl_neg   = -wl_pos;
        integ_next    = integ_reg;
        last_err_next = last_err_reg;
        if (cmd.load && restart)
        begin
            integ_next    = '0;
            last_err_next = '0;
        end
        else if (cmd.upd_int)
        begin
            last_err_next = err_reg;
            if (int_sum > wl_pos)
                integ_next = wl_pos[PosW-1:0];
            else if (int_sum < wl_neg)
                integ_next = wl_neg[PosW-1:0];
            else
                integ_next = int_sum[PosW-1:0];
        end
    end

    // derivative, saturated to 32 bits
    always_comb
    begin
        deriv_next = deriv_reg;
        if (cmd.upd_der)
        begin
            if (tick_period_reg == '0)
                deriv_next = '0;
            else if (!prod_q[AccW-1] && (|prod_q[AccW-2:PosW-1]))
                deriv_next = {1'b0, {(PosW-1){1'b1}}};
            else if (prod_q[AccW-1] && !(&prod_q[AccW-2:PosW-1]))
                deriv_next = {1'b1, {(PosW-1){1'b0}}};
            else
                deriv_next = prod_q[PosW-1:0];
        end
    end

    // product sum
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
            acc_next = '0;
        else if (cmd.acc_add)
            acc_next = acc_reg + prod_q;
    end

    // clamp to drive limit, truncate toward zero
    always_comb
    begin
        dl_pos = {{(AccW-GainW){1'b0}}, drive_limit_reg};
        if (acc_reg > dl_pos)
            sum_clamp = dl_pos[PosW-1:0];
        else if (acc_reg < -dl_pos)
            sum_clamp = -(dl_pos[PosW-1:0]);
        else
            sum_clamp = acc_reg[PosW-1:0];
        sum_mag    = sum_clamp[PosW-1] ? -sum_clamp : sum_clamp;
        drive_mag  = sum_mag[PosW-1:FracW];
        drive_next = sum_clamp[PosW-1] ? -drive_mag : drive_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            integ_reg    <= integ_next;
            last_err_reg <= last_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            err_reg <= err_sat;
        if (cmd.out_load)
            drive_reg <= drive_next;
        prod_reg  <= prod_next;
        deriv_reg <= deriv_next;
        acc_reg   <= acc_next;
    end

    assign drive = drive_reg;

endmodule

// File: sv/pidc_checker.sv
module pidc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [pidc_pkg::DriveW-1:0] drive
);
    import pidc_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive))
    else $error("drive changed or dropped while stalled");

    // one item in flight: no new item is taken from ST_MUL_INT through ST_ACC_D
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready
                                 ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("new item taken during computation");

    // a result only appears at the end of a computation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a computation");

endmodule

bind pid_position_controller pidc_checker u_pidc_checker (.*);
